FILE: src/bpsc_pkg.sv
`timescale 1ns / 1ps
// Package for the bone pose space converter: word types, micro-op table,
// rounding and saturation helpers. Used by every module in src; no dependencies.
package bpsc_pkg;

	// Input word: one bone as it arrives
	typedef struct packed {
		logic [7:0]         parent_index;
		logic signed [15:0] rot_w;
		logic signed [15:0] rot_x;
		logic signed [15:0] rot_y;
		logic signed [15:0] rot_z;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic               last_bone;
	} item_t;

	// Result word
	typedef struct packed {
		logic signed [15:0] out_w;
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic signed [15:0] out_z;
		logic signed [31:0] out_px;
		logic signed [31:0] out_py;
		logic signed [31:0] out_pz;
		logic               pose_end;
		logic               parent_error;
	} result_t;

	// One stored mesh-space bone
	typedef struct packed {
		logic signed [15:0] rot_w;
		logic signed [15:0] rot_x;
		logic signed [15:0] rot_y;
		logic signed [15:0] rot_z;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} bone_t;

	// Shared multiplier operand widths
	localparam int OPA_W  = 17;   // parent quaternion, conjugate needs +32768
	localparam int OPB_W  = 36;   // rotation, vector or cross term
	localparam int PROD_W = OPA_W + OPB_W;

	// Register indexes
	localparam logic CFG_DIRECTION = 1'b0;
	localparam logic CFG_WITH_TRANS = 1'b1;

	// B operand select codes
	localparam logic [3:0] B_QW = 4'd0;
	localparam logic [3:0] B_QX = 4'd1;
	localparam logic [3:0] B_QY = 4'd2;
	localparam logic [3:0] B_QZ = 4'd3;
	localparam logic [3:0] B_VX = 4'd4;
	localparam logic [3:0] B_VY = 4'd5;
	localparam logic [3:0] B_VZ = 4'd6;
	localparam logic [3:0] B_TX = 4'd7;
	localparam logic [3:0] B_TY = 4'd8;
	localparam logic [3:0] B_TZ = 4'd9;

	// Accumulation destinations
	localparam logic [3:0] D_RW = 4'd0;
	localparam logic [3:0] D_RX = 4'd1;
	localparam logic [3:0] D_RY = 4'd2;
	localparam logic [3:0] D_RZ = 4'd3;
	localparam logic [3:0] D_TX = 4'd4;
	localparam logic [3:0] D_TY = 4'd5;
	localparam logic [3:0] D_TZ = 4'd6;
	localparam logic [3:0] D_PX = 4'd7;
	localparam logic [3:0] D_PY = 4'd8;
	localparam logic [3:0] D_PZ = 4'd9;

	// Sequence points
	localparam logic [4:0] STEP_QEND = 5'd15;   // last quaternion product op
	localparam logic [4:0] STEP_TEND = 5'd21;   // last cross product op
	localparam logic [4:0] STEP_ROT  = 5'd22;   // first rotation op
	localparam logic [4:0] STEP_END  = 5'd30;

	typedef struct packed {
		logic [1:0] a;       // parent quaternion component
		logic [3:0] b;
		logic       neg;
		logic       first;
		logic       last;
		logic [3:0] dest;
	} op_t;

	// Control into the multiply-accumulate unit
	typedef struct packed {
		logic       valid;
		logic       neg;
		logic       first;
		logic       last;
		logic [3:0] dest;
	} mac_ctl_t;

	// Finished sum out of the unit
	typedef struct packed {
		logic       valid;
		logic [3:0] dest;
	} mac_res_t;

	function automatic op_t mk(input logic [1:0] a, input logic [3:0] b, input logic neg,
		input logic first, input logic last, input logic [3:0] dest);
		op_t o;
		o.a = a; o.b = b; o.neg = neg; o.first = first; o.last = last; o.dest = dest;
		return o;
	endfunction

	// Micro-op table: quaternion product, cross term, then rotation
	function automatic op_t op_at(input logic [4:0] step);
		op_t o;
		case (step)
			5'd0:  o = mk(2'd0, B_QW, 1'b0, 1'b1, 1'b0, D_RW);
			5'd1:  o = mk(2'd1, B_QX, 1'b1, 1'b0, 1'b0, D_RW);
			5'd2:  o = mk(2'd2, B_QY, 1'b1, 1'b0, 1'b0, D_RW);
			5'd3:  o = mk(2'd3, B_QZ, 1'b1, 1'b0, 1'b1, D_RW);
			5'd4:  o = mk(2'd0, B_QX, 1'b0, 1'b1, 1'b0, D_RX);
			5'd5:  o = mk(2'd1, B_QW, 1'b0, 1'b0, 1'b0, D_RX);
			5'd6:  o = mk(2'd2, B_QZ, 1'b0, 1'b0, 1'b0, D_RX);
			5'd7:  o = mk(2'd3, B_QY, 1'b1, 1'b0, 1'b1, D_RX);
			5'd8:  o = mk(2'd0, B_QY, 1'b0, 1'b1, 1'b0, D_RY);
			5'd9:  o = mk(2'd1, B_QZ, 1'b1, 1'b0, 1'b0, D_RY);
			5'd10: o = mk(2'd2, B_QW, 1'b0, 1'b0, 1'b0, D_RY);
			5'd11: o = mk(2'd3, B_QX, 1'b0, 1'b0, 1'b1, D_RY);
			5'd12: o = mk(2'd0, B_QZ, 1'b0, 1'b1, 1'b0, D_RZ);
			5'd13: o = mk(2'd1, B_QY, 1'b0, 1'b0, 1'b0, D_RZ);
			5'd14: o = mk(2'd2, B_QX, 1'b1, 1'b0, 1'b0, D_RZ);
			5'd15: o = mk(2'd3, B_QW, 1'b0, 1'b0, 1'b1, D_RZ);
			5'd16: o = mk(2'd2, B_VZ, 1'b0, 1'b1, 1'b0, D_TX);
			5'd17: o = mk(2'd3, B_VY, 1'b1, 1'b0, 1'b1, D_TX);
			5'd18: o = mk(2'd3, B_VX, 1'b0, 1'b1, 1'b0, D_TY);
			5'd19: o = mk(2'd1, B_VZ, 1'b1, 1'b0, 1'b1, D_TY);
			5'd20: o = mk(2'd1, B_VY, 1'b0, 1'b1, 1'b0, D_TZ);
			5'd21: o = mk(2'd2, B_VX, 1'b1, 1'b0, 1'b1, D_TZ);
			5'd22: o = mk(2'd0, B_TX, 1'b0, 1'b1, 1'b0, D_PX);
			5'd23: o = mk(2'd2, B_TZ, 1'b0, 1'b0, 1'b0, D_PX);
			5'd24: o = mk(2'd3, B_TY, 1'b1, 1'b0, 1'b1, D_PX);
			5'd25: o = mk(2'd0, B_TY, 1'b0, 1'b1, 1'b0, D_PY);
			5'd26: o = mk(2'd3, B_TX, 1'b0, 1'b0, 1'b0, D_PY);
			5'd27: o = mk(2'd1, B_TZ, 1'b1, 1'b0, 1'b1, D_PY);
			5'd28: o = mk(2'd0, B_TZ, 1'b0, 1'b1, 1'b0, D_PZ);
			5'd29: o = mk(2'd1, B_TY, 1'b0, 1'b0, 1'b0, D_PZ);
			5'd30: o = mk(2'd2, B_TX, 1'b1, 1'b0, 1'b1, D_PZ);
			default: o = mk(2'd0, B_QW, 1'b0, 1'b0, 1'b0, D_RW);
		endcase
		return o;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [37:0] v);
		if (v > 38'sd32767)
			return 16'sh7fff;
		else if (v < -38'sd32768)
			return 16'sh8000;
		else
			return v[15:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		if (v > 40'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -40'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage

FILE: src/bpsc_store.sv
`timescale 1ns / 1ps
// Bone store: mesh-space rotation and translation of every bone of the pose.
// Depends on bpsc_pkg for bone_t.
module bpsc_store #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  bpsc_pkg::bone_t  wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output bpsc_pkg::bone_t  rdata
);

	logic [63:0] rotation_store [DEPTH];
	logic [63:0] position_xy_store [DEPTH];
	logic [31:0] position_z_store [DEPTH];
	logic [63:0] rd_rot_q;
	logic [63:0] rd_xy_q;
	logic [31:0] rd_z_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			rotation_store[waddr]    <= {wdata.rot_w, wdata.rot_x, wdata.rot_y, wdata.rot_z};
			position_xy_store[waddr] <= {wdata.pos_x, wdata.pos_y};
			position_z_store[waddr]  <= wdata.pos_z;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rd_rot_q <= rotation_store[raddr];
			rd_xy_q  <= position_xy_store[raddr];
			rd_z_q   <= position_z_store[raddr];
		end
	end

	assign rdata.rot_w = rd_rot_q[63:48];
	assign rdata.rot_x = rd_rot_q[47:32];
	assign rdata.rot_y = rd_rot_q[31:16];
	assign rdata.rot_z = rd_rot_q[15:0];
	assign rdata.pos_x = rd_xy_q[63:32];
	assign rdata.pos_y = rd_xy_q[31:0];
	assign rdata.pos_z = rd_z_q;

endmodule

FILE: src/bpsc_mac.sv
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: registered 17x36 product, then signed accumulate.
// Depends on bpsc_pkg for widths and control structs.
module bpsc_mac (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic signed [bpsc_pkg::OPA_W-1:0]       op_a,
	input  logic signed [bpsc_pkg::OPB_W-1:0]       op_b,
	input  bpsc_pkg::mac_ctl_t                      ctl,
	output bpsc_pkg::mac_res_t                      res,
	output logic signed [bpsc_pkg::PROD_W-1:0]      acc
);

	logic signed [bpsc_pkg::PROD_W-1:0] prod_s1;
	bpsc_pkg::mac_ctl_t                 ctl_s1;
	logic signed [bpsc_pkg::PROD_W-1:0] acc_q;
	logic signed [bpsc_pkg::PROD_W-1:0] term;
	logic                               done_q;
	logic [3:0]                         dest_q;

	// multiply stage
	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	assign term = ctl_s1.neg ? -prod_s1 : prod_s1;

	// accumulate stage
	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			acc_q  <= (ctl_s1.first ? '0 : acc_q) + term;
			dest_q <= ctl_s1.dest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s1.valid & ctl_s1.last;
		end
	end

	assign res.valid = done_q;
	assign res.dest  = dest_q;
	assign acc       = acc_q;

endmodule

FILE: src/bone_pose_space_converter.sv
`timescale 1ns / 1ps
// Top level of the bone pose space converter: sequencer, operand muxing, results.
// Depends on bpsc_pkg, bpsc_store and bpsc_mac.
//
//  channel | signals                          | word
//  --------+----------------------------------+----------------------
//  item    | item_valid, item_stall, item     | bpsc_pkg::item_t
//  result  | result_valid, result_stall, result | bpsc_pkg::result_t
//  config  | cfg_we, cfg_index, cfg_data      | 1-bit register write
//
// A root or bad-parent bone goes from accept straight to S_FIN and is loaded into the
// result register there. Any other bone runs through one shared multiplier doing 16
// quaternion products, then, with translation, 6 cross and 9 rotation products, with a
// drain wait (S_WAIT) before the rotation products and at the end of the sequence.
// item_stall is high from accept until the result word is loaded; a full result
// register stalls the sequencer. Reset clears the bone counter, sequencer state, config
// and result valid flag; the bone store needs no clearing.
module bone_pose_space_converter #(
	parameter int MAX_BONES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  bpsc_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_stall,
	output bpsc_pkg::result_t   result,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic                cfg_data
);

	localparam int IW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOAD  = 3'd1;
	localparam logic [2:0] S_ISSUE = 3'd2;
	localparam logic [2:0] S_WAIT  = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0]               state_q;
	logic [4:0]               step_q;
	logic [1:0]               wait_q;
	logic [IW-1:0]            bone_q;
	logic                     direction_q;
	logic                     with_trans_q;
	bpsc_pkg::item_t          item_q;
	logic                     err_q;
	logic signed [16:0]       pq_q [4];
	logic signed [32:0]       v_q [3];
	logic signed [31:0]       pp_q [3];
	logic signed [35:0]       t_q [3];
	logic signed [15:0]       rq_q [4];
	logic signed [31:0]       rv_q [3];
	bpsc_pkg::result_t        result_q;
	logic                     result_valid_q;

	logic                     accept;
	logic                     fin_go;
	logic                     is_root;
	logic                     bad_parent;
	logic [16:0]              par_ext;
	logic [16:0]              me_ext;
	bpsc_pkg::bone_t          rd;
	bpsc_pkg::bone_t          wr;
	bpsc_pkg::op_t            op;
	bpsc_pkg::mac_ctl_t       ctl;
	bpsc_pkg::mac_res_t       mres;
	logic signed [bpsc_pkg::PROD_W-1:0] acc;
	logic signed [bpsc_pkg::OPA_W-1:0]  op_a;
	logic signed [bpsc_pkg::OPB_W-1:0]  op_b;
	logic signed [bpsc_pkg::PROD_W:0]   t_sum;
	logic signed [bpsc_pkg::PROD_W-1:0] r_sum;
	logic signed [bpsc_pkg::PROD_W-1:0] q_sum;
	logic signed [39:0]       p_sum;
	logic [1:0]               p_idx;
	logic signed [31:0]       p_base;

	assign accept     = item_valid & ~item_stall;
	assign item_stall = (state_q != S_IDLE);
	assign fin_go     = (state_q == S_FIN) & (~result_valid_q | ~result_stall);

	// parent check
	assign par_ext    = {9'd0, item.parent_index};
	assign me_ext     = 17'(bone_q);
	assign is_root    = (bone_q == '0);
	assign bad_parent = ~is_root & (par_ext >= me_ext);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q  <= 1'b0;
			with_trans_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				bpsc_pkg::CFG_DIRECTION:  direction_q  <= cfg_data;
				bpsc_pkg::CFG_WITH_TRANS: with_trans_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// parent store
	bpsc_store #(
		.DEPTH (MAX_BONES),
		.AW    (IW)
	) u_store (
		.clk   (clk),
		.we    (fin_go),
		.waddr (bone_q),
		.wdata (wr),
		.re    (accept),
		.raddr (par_ext[IW-1:0]),
		.rdata (rd)
	);

	// store write: mesh-space value of this bone
	always_comb begin
		if (direction_q) begin
			wr.rot_w = item_q.rot_w;
			wr.rot_x = item_q.rot_x;
			wr.rot_y = item_q.rot_y;
			wr.rot_z = item_q.rot_z;
			wr.pos_x = item_q.pos_x;
			wr.pos_y = item_q.pos_y;
			wr.pos_z = item_q.pos_z;
		end else begin
			wr.rot_w = rq_q[0];
			wr.rot_x = rq_q[1];
			wr.rot_y = rq_q[2];
			wr.rot_z = rq_q[3];
			wr.pos_x = rv_q[0];
			wr.pos_y = rv_q[1];
			wr.pos_z = rv_q[2];
		end
	end

	// operand select for the shared unit
	assign op   = bpsc_pkg::op_at(step_q);
	assign op_a = pq_q[op.a];

	always_comb begin
		case (op.b)
			bpsc_pkg::B_QW: op_b = 36'(item_q.rot_w);
			bpsc_pkg::B_QX: op_b = 36'(item_q.rot_x);
			bpsc_pkg::B_QY: op_b = 36'(item_q.rot_y);
			bpsc_pkg::B_QZ: op_b = 36'(item_q.rot_z);
			bpsc_pkg::B_VX: op_b = 36'(v_q[0]);
			bpsc_pkg::B_VY: op_b = 36'(v_q[1]);
			bpsc_pkg::B_VZ: op_b = 36'(v_q[2]);
			bpsc_pkg::B_TX: op_b = t_q[0];
			bpsc_pkg::B_TY: op_b = t_q[1];
			bpsc_pkg::B_TZ: op_b = t_q[2];
			default:        op_b = '0;
		endcase
	end

	assign ctl.valid = (state_q == S_ISSUE);
	assign ctl.neg   = op.neg;
	assign ctl.first = op.first;
	assign ctl.last  = op.last;
	assign ctl.dest  = op.dest;

	bpsc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op_a   (op_a),
		.op_b   (op_b),
		.ctl    (ctl),
		.res    (mres),
		.acc    (acc)
	);

	// rounding of finished sums
	assign q_sum  = (acc + bpsc_pkg::PROD_W'(16384)) >>> 15;
	assign t_sum  = ({acc, 1'b0} + (bpsc_pkg::PROD_W + 1)'(16384)) >>> 15;
	assign r_sum  = q_sum;
	assign p_idx  = 2'(mres.dest - bpsc_pkg::D_PX);
	assign p_base = direction_q ? 32'sd0 : pp_q[p_idx];
	assign p_sum  = 40'(v_q[p_idx]) + 40'(r_sum) + 40'(p_base);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			wait_q  <= '0;
			bone_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= (is_root | bad_parent) ? S_FIN : S_LOAD;
				end
				S_LOAD: begin
					step_q  <= '0;
					state_q <= S_ISSUE;
				end
				S_ISSUE: begin
					step_q <= step_q + 5'd1;
					if ((step_q == bpsc_pkg::STEP_QEND && !with_trans_q) ||
						step_q == bpsc_pkg::STEP_TEND || step_q == bpsc_pkg::STEP_END) begin
						wait_q  <= '0;
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					wait_q <= wait_q + 2'd1;
					if (wait_q == 2'd2)
						state_q <= (step_q == bpsc_pkg::STEP_ROT) ? S_ISSUE : S_FIN;
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
						if (item_q.last_bone || bone_q == IW'(MAX_BONES - 1))
							bone_q <= '0;
						else
							bone_q <= bone_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item capture, operand prep and result collection
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q  <= item;
			err_q   <= bad_parent;
			rq_q[0] <= item.rot_w;
			rq_q[1] <= item.rot_x;
			rq_q[2] <= item.rot_y;
			rq_q[3] <= item.rot_z;
			rv_q[0] <= item.pos_x;
			rv_q[1] <= item.pos_y;
			rv_q[2] <= item.pos_z;
		end
		if (state_q == S_LOAD) begin
			pq_q[0] <= 17'(rd.rot_w);
			pq_q[1] <= direction_q ? -17'(rd.rot_x) : 17'(rd.rot_x);
			pq_q[2] <= direction_q ? -17'(rd.rot_y) : 17'(rd.rot_y);
			pq_q[3] <= direction_q ? -17'(rd.rot_z) : 17'(rd.rot_z);
			pp_q[0] <= rd.pos_x;
			pp_q[1] <= rd.pos_y;
			pp_q[2] <= rd.pos_z;
			v_q[0]  <= direction_q ? 33'(item_q.pos_x) - 33'(rd.pos_x) : 33'(item_q.pos_x);
			v_q[1]  <= direction_q ? 33'(item_q.pos_y) - 33'(rd.pos_y) : 33'(item_q.pos_y);
			v_q[2]  <= direction_q ? 33'(item_q.pos_z) - 33'(rd.pos_z) : 33'(item_q.pos_z);
		end
		if (mres.valid) begin
			case (mres.dest)
				bpsc_pkg::D_RW: rq_q[0] <= bpsc_pkg::sat16(q_sum[37:0]);
				bpsc_pkg::D_RX: rq_q[1] <= bpsc_pkg::sat16(q_sum[37:0]);
				bpsc_pkg::D_RY: rq_q[2] <= bpsc_pkg::sat16(q_sum[37:0]);
				bpsc_pkg::D_RZ: rq_q[3] <= bpsc_pkg::sat16(q_sum[37:0]);
				bpsc_pkg::D_TX: t_q[0]  <= t_sum[35:0];
				bpsc_pkg::D_TY: t_q[1]  <= t_sum[35:0];
				bpsc_pkg::D_TZ: t_q[2]  <= t_sum[35:0];
				bpsc_pkg::D_PX: rv_q[0] <= bpsc_pkg::sat32(p_sum);
				bpsc_pkg::D_PY: rv_q[1] <= bpsc_pkg::sat32(p_sum);
				bpsc_pkg::D_PZ: rv_q[2] <= bpsc_pkg::sat32(p_sum);
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fin_go) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			result_q.out_w        <= rq_q[0];
			result_q.out_x        <= rq_q[1];
			result_q.out_y        <= rq_q[2];
			result_q.out_z        <= rq_q[3];
			result_q.out_px       <= rv_q[0];
			result_q.out_py       <= rv_q[1];
			result_q.out_pz       <= rv_q[2];
			result_q.pose_end     <= item_q.last_bone;
			result_q.parent_error <= err_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: verif/bpsc_checker.sv
`timescale 1ns / 1ps
// Checker for the bone pose space converter: follows the config port, predicts each
// result word from accepted bones and compares it with the result channel.
// Depends on bpsc_pkg.
module bpsc_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_stall,
	input  bpsc_pkg::item_t   item,
	input  logic              result_valid,
	input  logic              result_stall,
	input  bpsc_pkg::result_t result,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic              cfg_data,
	output int                pending,
	output int                errors
);

	typedef longint quat_t[4];
	typedef longint vec_t[3];

	// Mirror of the block's state
	bpsc_pkg::bone_t   mesh_bones[256];
	logic [7:0]        bone_idx;
	logic              to_local;
	logic              conv_pos;
	bpsc_pkg::result_t expected_words[$];

	function automatic longint round_q15(input longint a);
		return (a + 64'sd16384) >>> 15;
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Hamilton product p * q, rounded and saturated to Q1.15
	function automatic void quat_mul(input quat_t p, input quat_t q, output quat_t r);
		longint s[4];
		s[0] = p[0]*q[0] - p[1]*q[1] - p[2]*q[2] - p[3]*q[3];
		s[1] = p[0]*q[1] + p[1]*q[0] + p[2]*q[3] - p[3]*q[2];
		s[2] = p[0]*q[2] - p[1]*q[3] + p[2]*q[0] + p[3]*q[1];
		s[3] = p[0]*q[3] + p[1]*q[2] - p[2]*q[1] + p[3]*q[0];
		for (int i = 0; i < 4; i++)
			r[i] = clamp(round_q15(s[i]), -32768, 32767);
	endfunction

	// v rotated by q through the doubled cross term, left unsaturated
	function automatic void vec_rotate(input quat_t q, input vec_t v, output vec_t r);
		longint t[3];
		t[0] = round_q15(2 * (q[2]*v[2] - q[3]*v[1]));
		t[1] = round_q15(2 * (q[3]*v[0] - q[1]*v[2]));
		t[2] = round_q15(2 * (q[1]*v[1] - q[2]*v[0]));
		r[0] = v[0] + round_q15(q[0]*t[0] + q[2]*t[2] - q[3]*t[1]);
		r[1] = v[1] + round_q15(q[0]*t[1] + q[3]*t[0] - q[1]*t[2]);
		r[2] = v[2] + round_q15(q[0]*t[2] + q[1]*t[1] - q[2]*t[0]);
	endfunction

	// Converts one bone and updates the mirrored store and counter
	function automatic bpsc_pkg::result_t convert_bone(input bpsc_pkg::item_t w);
		quat_t             q, pq, rq;
		vec_t              v, pv, rv, d, t;
		bpsc_pkg::result_t r;
		logic              bad;
		bpsc_pkg::bone_t   par, keep;
		q  = '{w.rot_w, w.rot_x, w.rot_y, w.rot_z};
		v  = '{w.pos_x, w.pos_y, w.pos_z};
		rq = q;
		rv = v;
		bad = (bone_idx != 0) && (w.parent_index >= bone_idx);
		if (bone_idx != 0 && !bad) begin
			par = mesh_bones[w.parent_index];
			pq = '{par.rot_w, par.rot_x, par.rot_y, par.rot_z};
			pv = '{par.pos_x, par.pos_y, par.pos_z};
			if (!to_local) begin
				quat_mul(pq, q, rq);
				if (conv_pos) begin
					vec_rotate(pq, v, t);
					for (int i = 0; i < 3; i++)
						rv[i] = clamp(pv[i] + t[i], -64'sd2147483648, 64'sd2147483647);
				end
			end else begin
				pq[1] = -pq[1];
				pq[2] = -pq[2];
				pq[3] = -pq[3];
				quat_mul(pq, q, rq);
				if (conv_pos) begin
					for (int i = 0; i < 3; i++)
						d[i] = v[i] - pv[i];
					vec_rotate(pq, d, t);
					for (int i = 0; i < 3; i++)
						rv[i] = clamp(t[i], -64'sd2147483648, 64'sd2147483647);
				end
			end
		end
		r.out_w = rq[0][15:0];
		r.out_x = rq[1][15:0];
		r.out_y = rq[2][15:0];
		r.out_z = rq[3][15:0];
		r.out_px = rv[0][31:0];
		r.out_py = rv[1][31:0];
		r.out_pz = rv[2][31:0];
		r.pose_end = w.last_bone;
		r.parent_error = bad;
		// store keeps mesh space: the result going down, the input going up
		if (!to_local) begin
			keep = '{r.out_w, r.out_x, r.out_y, r.out_z, r.out_px, r.out_py, r.out_pz};
		end else begin
			keep = '{w.rot_w, w.rot_x, w.rot_y, w.rot_z, w.pos_x, w.pos_y, w.pos_z};
		end
		mesh_bones[bone_idx] = keep;
		bone_idx = w.last_bone ? 8'd0 : bone_idx + 8'd1;
		return r;
	endfunction

	// Watch all three ports
	always @(posedge clk or negedge arst_n) begin
		bpsc_pkg::result_t want;
		if (!arst_n) begin
			bone_idx = '0;
			to_local = 1'b0;
			conv_pos = 1'b0;
			expected_words.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == bpsc_pkg::CFG_DIRECTION)
					to_local = cfg_data;
				else if (cfg_index == bpsc_pkg::CFG_WITH_TRANS)
					conv_pos = cfg_data;
			end
			if (item_valid && !item_stall)
				expected_words.push_back(convert_bone(item));
			if (result_valid && !result_stall) begin
				if (expected_words.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result word %h", result);
				end else begin
					want = expected_words.pop_front();
					if (result !== want) begin
						errors++;
						if (errors <= 10)
							$display({"mismatch: w %h/%h x %h/%h y %h/%h z %h/%h ",
								"px %h/%h py %h/%h pz %h/%h end %b/%b err %b/%b (exp/got)"},
								want.out_w, result.out_w, want.out_x, result.out_x,
								want.out_y, result.out_y, want.out_z, result.out_z,
								want.out_px, result.out_px, want.out_py, result.out_py,
								want.out_pz, result.out_pz, want.pose_end, result.pose_end,
								want.parent_error, result.parent_error);
					end
				end
			end
		end
		pending = expected_words.size();
	end

endmodule

FILE: verif/bone_pose_space_converter_test.sv
`timescale 1ns / 1ps
// Testbench top for the bone pose space converter: clock, reset, bone stimulus,
// config phases and the verdict. Depends on bpsc_pkg, bpsc_checker and the block.
module bone_pose_space_converter_test;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	bpsc_pkg::item_t   item = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	bpsc_pkg::result_t result;
	logic              cfg_we = 1'b0;
	logic              cfg_index = 1'b0;
	logic              cfg_data = 1'b0;
	int                pending;
	int                errors;

	int         send_gap_pct = 0;
	int         recv_stall_pct = 0;
	logic [7:0] next_bone = '0;

	bone_pose_space_converter dut (.*);
	bpsc_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver back-pressure
	always @(posedge clk)
		result_stall <= ($urandom_range(99) < recv_stall_pct);

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// One bone word; valid stays high across back-to-back words
	task automatic send_bone(input bpsc_pkg::item_t w);
		if ($urandom_range(99) < send_gap_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		next_bone = w.last_bone ? 8'd0 : next_bone + 8'd1;
	endtask

	// Register write only with the block drained
	task automatic set_mode(input logic dir, input logic trans);
		item_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (60) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= bpsc_pkg::CFG_DIRECTION;
		cfg_data <= dir;
		@(posedge clk);
		cfg_index <= bpsc_pkg::CFG_WITH_TRANS;
		cfg_data <= trans;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] rand_rot();
		if ($urandom_range(2) == 0)
			return 16'($urandom);
		return 16'($urandom_range(32767) - 16384);
	endfunction

	function automatic logic [31:0] rand_pos();
		if ($urandom_range(2) == 0)
			return $urandom;
		return $urandom_range(2097151) - 1048576;
	endfunction

	// Random bone: mostly a valid parent, sometimes a bad one
	function automatic bpsc_pkg::item_t rand_bone(input logic [7:0] idx, input logic last);
		bpsc_pkg::item_t w;
		w.rot_w = rand_rot();
		w.rot_x = rand_rot();
		w.rot_y = rand_rot();
		w.rot_z = rand_rot();
		w.pos_x = rand_pos();
		w.pos_y = rand_pos();
		w.pos_z = rand_pos();
		w.last_bone = last;
		if (idx == 0 || $urandom_range(9) == 0)
			w.parent_index = (idx == 0) ? 8'($urandom_range(255)) :
				8'($urandom_range(255, idx));
		else
			w.parent_index = 8'($urandom_range(idx - 1));
		return w;
	endfunction

	task automatic random_poses(input int count, input logic long_pose);
		int n;
		int pose_len;
		n = 0;
		while (n < count) begin
			pose_len = long_pose ? 260 : $urandom_range(1, 10);
			long_pose = 1'b0;
			for (int b = 0; b < pose_len; b++) begin
				send_bone(rand_bone(next_bone, b == pose_len - 1 && pose_len != 260));
				n++;
				// hold off once until the pipe is empty
				if (n == count / 2 && recv_stall_pct == 6) begin
					item_valid <= 1'b0;
					@(posedge clk);
					wait (pending == 0);
				end
			end
		end
	endtask

	initial begin
		bpsc_pkg::item_t w;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, bad parents, pass-through
		set_mode(1'b0, 1'b1);
		w = '{8'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0};
		send_bone(w);
		w = '{8'd0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0};
		send_bone(w);
		w = '{8'd1, 16'sh7fff, 16'sh0, 16'sh0, 16'sh0, 32'sh1000, 32'sh0, 32'sh0, 1'b0};
		send_bone(w);
		w = '{8'd3, 16'sh5a82, 16'sh5a82, 16'sh0, 16'sh0, 32'sh2000, 32'sh3000, 32'sh0, 1'b0};
		send_bone(w);
		w = '{8'd255, 16'sh0, 16'sh8000, 16'sh0, 16'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b0};
		send_bone(w);
		w = '{8'd2, 16'sh0, 16'sh0, 16'sh7fff, 16'sh0, 32'sh0, 32'sh7fffffff, 32'sh0, 1'b1};
		send_bone(w);
		for (int i = 0; i < 6; i++)
			send_bone(rand_bone(next_bone, i == 5));
		set_mode(1'b1, 1'b1);
		send_bone(w);
		w = '{8'd0, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
			32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b0};
		send_bone(w);
		w = '{8'd1, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
			32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0};
		send_bone(w);
		w.parent_index = 8'd2;
		w.last_bone = 1'b1;
		send_bone(w);

		// Random phases across modes and idle patterns
		send_gap_pct = 6;
		recv_stall_pct = 54;
		set_mode(1'b0, 1'b0);
		random_poses(170, 1'b0);
		set_mode(1'b1, 1'b0);
		random_poses(170, 1'b0);
		send_gap_pct = 54;
		recv_stall_pct = 6;
		set_mode(1'b0, 1'b1);
		random_poses(170, 1'b1);
		set_mode(1'b1, 1'b1);
		random_poses(170, 1'b0);
		send_gap_pct = 0;
		recv_stall_pct = 0;
		set_mode(1'b0, 1'b1);
		random_poses(170, 1'b0);
		set_mode(1'b1, 1'b1);
		random_poses(170, 1'b0);

		item_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
